@@ hw/rtl/hlfe_pkg.sv @@
package hlfe_pkg;

  localparam int LANDMARK_COUNT = 21;
  localparam int NUM_ANGLES     = 15;
  localparam int NUM_FEATURES   = 30;
  localparam int QUEUE_DEPTH    = 4;
  localparam int CORDIC_STEPS   = 16;
  localparam int HALF_PI_Q16    = 102944;
  localparam int PI_Q16         = 205887;
  localparam int PI_Q14         = 51472;
  localparam int FEAT_MAX       = 65535;

  typedef logic [4:0] lm_idx_t;

  localparam lm_idx_t LM_LAST       = lm_idx_t'(LANDMARK_COUNT - 1);
  localparam lm_idx_t LAST_FEATURE  = lm_idx_t'(NUM_FEATURES - 1);
  localparam lm_idx_t FIRST_DIST    = lm_idx_t'(NUM_ANGLES);
  localparam lm_idx_t WRIST         = 5'd0;
  localparam lm_idx_t MID_KNUCKLE   = 5'd9;

  // queue command: landmark load or feature job
  typedef struct packed {
    logic    is_job;
    lm_idx_t idx;
  } cmd_t;

  // joint triplets (outer, joint, inner)
  localparam lm_idx_t ANG_P [NUM_ANGLES] = '{
    5'd0, 5'd1, 5'd2, 5'd0, 5'd5, 5'd6, 5'd0, 5'd9, 5'd10,
    5'd0, 5'd13, 5'd14, 5'd0, 5'd17, 5'd18};
  localparam lm_idx_t ANG_J [NUM_ANGLES] = '{
    5'd1, 5'd2, 5'd3, 5'd5, 5'd6, 5'd7, 5'd9, 5'd10, 5'd11,
    5'd13, 5'd14, 5'd15, 5'd17, 5'd18, 5'd19};
  localparam lm_idx_t ANG_C [NUM_ANGLES] = '{
    5'd2, 5'd3, 5'd4, 5'd6, 5'd7, 5'd8, 5'd10, 5'd11, 5'd12,
    5'd14, 5'd15, 5'd16, 5'd18, 5'd19, 5'd20};

  // distance pairs
  localparam lm_idx_t DIST_A [NUM_ANGLES] = '{
    5'd4, 5'd4, 5'd4, 5'd4, 5'd8, 5'd8, 5'd8, 5'd12, 5'd12, 5'd16,
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
  localparam lm_idx_t DIST_B [NUM_ANGLES] = '{
    5'd8, 5'd12, 5'd16, 5'd20, 5'd12, 5'd16, 5'd20, 5'd16, 5'd20, 5'd20,
    5'd4, 5'd8, 5'd12, 5'd16, 5'd20};

  localparam logic [16:0] ATAN_Q16 [CORDIC_STEPS] = '{
    17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047,
    17'd1024, 17'd512, 17'd256, 17'd128, 17'd64, 17'd32, 17'd16,
    17'd8, 17'd4, 17'd2};

endpackage

@@ hw/rtl/hlfe_front.sv @@
module hlfe_front #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_coord_x,
  input  logic signed [COORD_WIDTH-1:0] in_coord_y,
  input  logic signed [COORD_WIDTH-1:0] in_coord_z,
  output logic                          push_valid,
  input  logic                          push_ready,
  output hlfe_pkg::cmd_t                push_cmd,
  output logic [3*COORD_WIDTH-1:0]      push_coords
);
  import hlfe_pkg::*;

  lm_idx_t cnt_r;
  lm_idx_t gen_idx_r;
  logic    gen_r;
  logic    accept;

  // landmark words are blocked while the job list of a hand is issued
  assign in_ready   = !gen_r && push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = gen_r || in_valid;

  assign push_cmd.is_job = gen_r;
  assign push_cmd.idx    = gen_r ? gen_idx_r : cnt_r;
  assign push_coords     = gen_r ? '0 : {in_coord_z, in_coord_y, in_coord_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      gen_r     <= 1'b0;
      gen_idx_r <= '0;
    end else begin
      if (accept) begin
        if (cnt_r == LM_LAST) begin
          cnt_r     <= '0;
          gen_r     <= 1'b1;
          gen_idx_r <= '0;
        end else begin
          cnt_r <= cnt_r + 5'd1;
        end
      end
      if (gen_r && push_ready) begin
        if (gen_idx_r == LAST_FEATURE) begin
          gen_r <= 1'b0;
        end else begin
          gen_idx_r <= gen_idx_r + 5'd1;
        end
      end
    end
  end

endmodule

@@ hw/rtl/hlfe_queue.sv @@
module hlfe_queue #(
  parameter int W = 54
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);
  import hlfe_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [W-1:0] slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic          push, pop;

  assign wr_ready = cnt_r != (PW+1)'(QUEUE_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = slot_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PW'(1);
      if (pop)  rp_r <= rp_r + PW'(1);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (PW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (PW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ hw/rtl/hlfe_back.sv @@
module hlfe_back #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  output logic                     q_ready,
  input  hlfe_pkg::cmd_t           q_cmd,
  input  logic [3*COORD_WIDTH-1:0] q_coords,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [4:0]               out_feature_index,
  output logic [15:0]              out_feature_value,
  output logic                     out_saturated,
  output logic                     out_last_feature
);
  import hlfe_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int VW    = CW + 1;
  localparam int K     = (CW > 16) ? CW - 16 : 0;
  localparam int DWID  = VW - K;
  localparam int SQW   = 2 * DWID;
  localparam int DVW   = SQW + 24;
  localparam int DCW   = $clog2(DVW + 1);
  localparam int MW    = 33;
  localparam int ACC_W = 36;
  localparam int CXW   = 38;
  localparam int ZW    = 20;
  localparam logic signed [VW-1:0] KDIV = VW'(1 << K);
  localparam logic signed [VW-1:0] TWO  = VW'(2);
  localparam logic [63:0] ZMAX = 64'(FEAT_MAX >> K);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_PREP, ST_SHRINK, ST_MUL, ST_SQRT, ST_CORD, ST_DIV, ST_FIN
  } state_t;

  state_t state_r;
  lm_idx_t idx_r;
  logic [2:0] rcnt_r;
  logic [3*CW-1:0] store_mem [LANDMARK_COUNT];
  logic [3*CW-1:0] rdata_r;
  logic [3*CW-1:0] pt_r [4];
  logic signed [VW-1:0] u_r [3];
  logic signed [VW-1:0] w_r [3];
  logic zero_r;
  logic [3:0] mcnt_r, pstep_r;
  logic pv_r;
  logic signed [63:0] prod_r;
  logic signed [ACC_W-1:0] dot_r, s2_r;
  logic signed [MW-1:0] c_r [3];
  logic [63:0] sq_r, sqn_r, sqr_r, sqb_r;
  logic signed [CXW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] cz_r;
  logic [4:0] ci_r;
  logic [SQW-1:0] rem_r;
  logic [DVW-1:0] quo_r;
  logic [DCW-1:0] dcnt_r;
  logic out_valid_r, out_saturated_r, out_last_feature_r;
  logic [4:0] out_feature_index_r;
  logic [15:0] out_feature_value_r;

  logic is_dist;
  logic [3:0] ai, di;
  lm_idx_t raddr;
  logic [2:0] rprev;
  logic mem_we;
  logic signed [CW-1:0] pc [4][3];
  logic signed [VW-1:0] dv1 [3], dv2 [3];
  logic vzero, ubig, wbig;
  logic [3:0] nsteps;
  logic signed [MW-1:0] opa, opb;
  logic signed [2*MW-1:0] mprod;
  logic [63:0] sq_t;
  logic signed [CXW-1:0] y0, x0;
  logic [SQW:0] trial;
  logic [SQW:0] divisor;
  logic [ZW-1:0] zc;
  logic [ZW-1:0] zr;
  logic [15:0] res_val;
  logic res_sat;
  lm_idx_t dist_i;

  assign is_dist = idx_r >= FIRST_DIST;
  assign ai      = idx_r[3:0];
  assign dist_i  = idx_r - FIRST_DIST;
  assign di      = dist_i[3:0];
  assign rprev   = rcnt_r - 3'd1;
  assign q_ready = state_r == ST_IDLE;
  assign mem_we  = q_ready && q_valid && !q_cmd.is_job;

  always_comb begin
    case (rcnt_r[1:0])
      2'd0:    raddr = is_dist ? DIST_A[di] : ANG_P[ai];
      2'd1:    raddr = is_dist ? DIST_B[di] : ANG_J[ai];
      2'd2:    raddr = is_dist ? MID_KNUCKLE : ANG_C[ai];
      default: raddr = WRIST;
    endcase
  end

  // landmark store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[q_cmd.idx] <= q_coords;
    end
    rdata_r <= store_mem[raddr];
  end

  // vector set-up: angle vectors from the joint, distance vectors scaled down
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      for (int k = 0; k < 3; k++) begin
        pc[n][k] = $signed(pt_r[n][k*CW +: CW]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (is_dist) begin
        dv1[k] = (VW'(pc[0][k]) - VW'(pc[1][k])) / KDIV;
        dv2[k] = (VW'(pc[2][k]) - VW'(pc[3][k])) / KDIV;
      end else begin
        dv1[k] = VW'(pc[0][k]) - VW'(pc[1][k]);
        dv2[k] = VW'(pc[2][k]) - VW'(pc[1][k]);
      end
    end
    vzero = (dv1[0] == '0 && dv1[1] == '0 && dv1[2] == '0) ||
            (dv2[0] == '0 && dv2[1] == '0 && dv2[2] == '0);
    ubig = 1'b0;
    wbig = 1'b0;
    for (int k = 0; k < 3; k++) begin
      ubig = ubig || (u_r[k] >= 32768) || (u_r[k] <= -32768);
      wbig = wbig || (w_r[k] >= 32768) || (w_r[k] <= -32768);
    end
  end

  // shared multiplier operand select
  always_comb begin
    nsteps = is_dist ? 4'd6 : 4'd12;
    opa = '0;
    opb = '0;
    if (is_dist) begin
      case (mcnt_r)
        4'd0:    begin opa = MW'(u_r[0]); opb = MW'(u_r[0]); end
        4'd1:    begin opa = MW'(u_r[1]); opb = MW'(u_r[1]); end
        4'd2:    begin opa = MW'(u_r[2]); opb = MW'(u_r[2]); end
        4'd3:    begin opa = MW'(w_r[0]); opb = MW'(w_r[0]); end
        4'd4:    begin opa = MW'(w_r[1]); opb = MW'(w_r[1]); end
        default: begin opa = MW'(w_r[2]); opb = MW'(w_r[2]); end
      endcase
    end else begin
      case (mcnt_r)
        4'd0:    begin opa = MW'(u_r[0]); opb = MW'(w_r[0]); end
        4'd1:    begin opa = MW'(u_r[1]); opb = MW'(w_r[1]); end
        4'd2:    begin opa = MW'(u_r[2]); opb = MW'(w_r[2]); end
        4'd3:    begin opa = MW'(u_r[1]); opb = MW'(w_r[2]); end
        4'd4:    begin opa = MW'(u_r[2]); opb = MW'(w_r[1]); end
        4'd5:    begin opa = MW'(u_r[2]); opb = MW'(w_r[0]); end
        4'd6:    begin opa = MW'(u_r[0]); opb = MW'(w_r[2]); end
        4'd7:    begin opa = MW'(u_r[0]); opb = MW'(w_r[1]); end
        4'd8:    begin opa = MW'(u_r[1]); opb = MW'(w_r[0]); end
        4'd9:    begin opa = c_r[0]; opb = c_r[0]; end
        4'd10:   begin opa = c_r[1]; opb = c_r[1]; end
        default: begin opa = c_r[2]; opb = c_r[2]; end
      endcase
    end
  end

  assign mprod   = opa * opb;
  assign sq_t    = sqr_r + sqb_r;
  assign y0      = $signed({{(CXW-32){1'b0}}, sqr_r[31:0]});
  assign x0      = CXW'(dot_r);
  assign trial   = {rem_r, quo_r[DVW-1]};
  assign divisor = {1'b0, s2_r[SQW-1:0]};

  // result formatting
  always_comb begin
    if (cz_r < 0) begin
      zc = '0;
    end else if (cz_r > ZW'(PI_Q16)) begin
      zc = ZW'(PI_Q16);
    end else begin
      zc = cz_r;
    end
    zr = (zc + ZW'(2)) >> 2;
    res_sat = 1'b0;
    if (!is_dist) begin
      if (zero_r) begin
        res_val = '0;
      end else if (zr > ZW'(PI_Q14)) begin
        res_val = 16'(PI_Q14);
      end else begin
        res_val = zr[15:0];
      end
    end else if (s2_r == '0) begin
      if (sqr_r > ZMAX) begin
        res_val = 16'(FEAT_MAX);
        res_sat = 1'b1;
      end else begin
        res_val = sqr_r[15:0] << K;
      end
    end else if (sqr_r > 64'(FEAT_MAX)) begin
      res_val = 16'(FEAT_MAX);
      res_sat = 1'b1;
    end else begin
      res_val = sqr_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != ST_FIN) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (q_valid && q_cmd.is_job) begin
            idx_r   <= q_cmd.idx;
            rcnt_r  <= '0;
            state_r <= ST_RD;
          end
        end
        ST_RD: begin
          rcnt_r <= rcnt_r + 3'd1;
          if (rcnt_r != 3'd0) pt_r[rprev[1:0]] <= rdata_r;
          if (rcnt_r == 3'd4) state_r <= ST_PREP;
        end
        ST_PREP: begin
          u_r    <= dv1;
          w_r    <= dv2;
          mcnt_r <= '0;
          pv_r   <= 1'b0;
          zero_r <= 1'b0;
          if (is_dist) begin
            state_r <= ST_MUL;
          end else if (vzero) begin
            zero_r  <= 1'b1;
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_SHRINK;
          end
        end
        ST_SHRINK: begin
          if (ubig) begin
            for (int k = 0; k < 3; k++) u_r[k] <= u_r[k] / TWO;
          end
          if (wbig) begin
            for (int k = 0; k < 3; k++) w_r[k] <= w_r[k] / TWO;
          end
          if (!ubig && !wbig) state_r <= ST_MUL;
        end
        ST_MUL: begin
          if (mcnt_r < nsteps) begin
            prod_r  <= $signed(mprod[63:0]);
            pstep_r <= mcnt_r;
            pv_r    <= 1'b1;
            mcnt_r  <= mcnt_r + 4'd1;
          end else if (pv_r) begin
            pv_r <= 1'b0;
          end else if (!is_dist) begin
            sqn_r   <= sq_r;
            sqr_r   <= '0;
            sqb_r   <= 64'd1 << 62;
            state_r <= ST_SQRT;
          end else if (s2_r == '0) begin
            sqn_r   <= {{(64-SQW){1'b0}}, dot_r[SQW-1:0]};
            sqr_r   <= '0;
            sqb_r   <= 64'd1 << 62;
            state_r <= ST_SQRT;
          end else begin
            quo_r   <= {dot_r[SQW-1:0], 24'd0};
            rem_r   <= '0;
            dcnt_r  <= '0;
            state_r <= ST_DIV;
          end
          if (pv_r) begin
            if (is_dist) begin
              case (pstep_r)
                4'd0:    dot_r <= $signed(prod_r[ACC_W-1:0]);
                4'd1,
                4'd2:    dot_r <= dot_r + $signed(prod_r[ACC_W-1:0]);
                4'd3:    s2_r  <= $signed(prod_r[ACC_W-1:0]);
                default: s2_r  <= s2_r + $signed(prod_r[ACC_W-1:0]);
              endcase
            end else begin
              case (pstep_r)
                4'd0:    dot_r  <= $signed(prod_r[ACC_W-1:0]);
                4'd1,
                4'd2:    dot_r  <= dot_r + $signed(prod_r[ACC_W-1:0]);
                4'd3:    c_r[0] <= $signed(prod_r[MW-1:0]);
                4'd4:    c_r[0] <= c_r[0] - $signed(prod_r[MW-1:0]);
                4'd5:    c_r[1] <= $signed(prod_r[MW-1:0]);
                4'd6:    c_r[1] <= c_r[1] - $signed(prod_r[MW-1:0]);
                4'd7:    c_r[2] <= $signed(prod_r[MW-1:0]);
                4'd8:    c_r[2] <= c_r[2] - $signed(prod_r[MW-1:0]);
                4'd9:    sq_r   <= $unsigned(prod_r);
                default: sq_r   <= sq_r + $unsigned(prod_r);
              endcase
            end
          end
        end
        ST_DIV: begin
          if (dcnt_r < DCW'(DVW)) begin
            if (trial >= divisor) begin
              rem_r <= SQW'(trial - divisor);
              quo_r <= {quo_r[DVW-2:0], 1'b1};
            end else begin
              rem_r <= trial[SQW-1:0];
              quo_r <= {quo_r[DVW-2:0], 1'b0};
            end
            dcnt_r <= dcnt_r + DCW'(1);
          end else begin
            sqn_r   <= {{(64-DVW){1'b0}}, quo_r};
            sqr_r   <= '0;
            sqb_r   <= 64'd1 << 62;
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sqb_r != '0) begin
            if (sqn_r >= sq_t) begin
              sqn_r <= sqn_r - sq_t;
              sqr_r <= (sqr_r >> 1) + sqb_r;
            end else begin
              sqr_r <= sqr_r >> 1;
            end
            sqb_r <= sqb_r >> 2;
          end else if (is_dist) begin
            state_r <= ST_FIN;
          end else begin
            // obtuse case: start from the -90 degree rotated vector
            if (dot_r < 0) begin
              cx_r <= y0;
              cy_r <= -x0;
              cz_r <= ZW'(HALF_PI_Q16);
            end else begin
              cx_r <= x0;
              cy_r <= y0;
              cz_r <= '0;
            end
            ci_r    <= '0;
            state_r <= ST_CORD;
          end
        end
        ST_CORD: begin
          if (ci_r == 5'(CORDIC_STEPS) || cy_r == '0) begin
            state_r <= ST_FIN;
          end else begin
            if (cy_r > 0) begin
              cx_r <= cx_r + (cy_r >>> ci_r);
              cy_r <= cy_r - (cx_r >>> ci_r);
              cz_r <= cz_r + $signed({3'b000, ATAN_Q16[ci_r[3:0]]});
            end else begin
              cx_r <= cx_r - (cy_r >>> ci_r);
              cy_r <= cy_r + (cx_r >>> ci_r);
              cz_r <= cz_r - $signed({3'b000, ATAN_Q16[ci_r[3:0]]});
            end
            ci_r <= ci_r + 5'd1;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r         <= 1'b1;
            out_feature_index_r <= idx_r;
            out_feature_value_r <= res_val;
            out_saturated_r     <= res_sat;
            out_last_feature_r  <= idx_r == LAST_FEATURE;
            state_r             <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_feature_index = out_feature_index_r;
  assign out_feature_value = out_feature_value_r;
  assign out_saturated     = out_saturated_r;
  assign out_last_feature  = out_last_feature_r;

  a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CORD) |-> (ci_r <= 5'(CORDIC_STEPS)))
    else $error("cordic step count out of range");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_feature_r) |-> (out_feature_index_r == LAST_FEATURE))
    else $error("last flag on wrong feature");

  a_sat_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_saturated_r) |-> (out_feature_index_r >= FIRST_DIST))
    else $error("saturation flag on an angle");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_feature_index_r < FIRST_DIST) |->
      (out_feature_value_r <= 16'(PI_Q14)))
    else $error("angle above pi");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (s2_r != '0))
    else $error("divide by zero hand length");

endmodule

@@ hw/rtl/hand_landmark_feature_extractor.sv @@
// Channel  Ports                                        Dir  Word
// in       in_valid/in_ready, in_coord_x/y/z            in   one landmark, signed Q3.12
// out      out_valid/out_ready, out_feature_index,      out  one feature: index, value,
//          out_feature_value, out_saturated,                 saturate flag, last flag
//          out_last_feature
//
// Landmark words are taken back to back while the queue has room; after the 21st the
// front holds in_ready low and queues 30 feature jobs as the back drains the queue.
// The back takes one job at a time: an angle with a zero vector skips the arithmetic,
// and a distance at zero hand length skips the division.
// Reset (rst_n low, synchronous) empties the queue and the landmark count; the store
// has none. A stalled out_ready holds one result while the back finishes the next.
module hand_landmark_feature_extractor #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_coord_x,
  input  logic signed [COORD_WIDTH-1:0] in_coord_y,
  input  logic signed [COORD_WIDTH-1:0] in_coord_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [4:0]                    out_feature_index,
  output logic [15:0]                   out_feature_value,
  output logic                          out_saturated,
  output logic                          out_last_feature
);
  import hlfe_pkg::*;

  localparam int QW = $bits(cmd_t) + 3 * COORD_WIDTH;

  // front -> queue
  logic                     push_valid, push_ready;
  cmd_t                     push_cmd;
  logic [3*COORD_WIDTH-1:0] push_coords;

  // queue -> back
  logic                     pop_valid, pop_ready;
  logic [QW-1:0]            pop_word;
  cmd_t                     pop_cmd;
  logic [3*COORD_WIDTH-1:0] pop_coords;

  assign pop_cmd    = pop_word[QW-1 -: $bits(cmd_t)];
  assign pop_coords = pop_word[3*COORD_WIDTH-1:0];

  hlfe_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_coord_x  (in_coord_x),
    .in_coord_y  (in_coord_y),
    .in_coord_z  (in_coord_z),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_cmd    (push_cmd),
    .push_coords (push_coords)
  );

  hlfe_queue #(.W(QW)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  ({push_cmd, push_coords}),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_word)
  );

  hlfe_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (pop_valid),
    .q_ready           (pop_ready),
    .q_cmd             (pop_cmd),
    .q_coords          (pop_coords),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_feature_index (out_feature_index),
    .out_feature_value (out_feature_value),
    .out_saturated     (out_saturated),
    .out_last_feature  (out_last_feature)
  );

endmodule

@@ dv/hand_landmark_feature_extractor_tb.sv @@
`timescale 1ns / 100ps

module hand_landmark_feature_extractor_tb;
  import hlfe_pkg::*;

  typedef logic signed [15:0] coord_t;

  // one feature word as the block should emit it
  typedef struct packed {
    logic [4:0]  idx;
    logic [15:0] value;
    logic        sat;
    logic        last;
  } feature_t;

  // shapes of random hands
  typedef enum int {
    HAND_NATURAL,   // wrist anywhere, fingers close by
    HAND_SCATTER,   // every coordinate over the full range
    HAND_DEGEN,     // points drawn from a tiny set: zero and collinear vectors
    HAND_FLAT       // middle knuckle on the wrist: zero hand length
  } hand_kind_t;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  coord_t in_coord_x, in_coord_y, in_coord_z;
  logic   out_valid;
  logic   out_ready;
  logic [4:0]  out_feature_index;
  logic [15:0] out_feature_value;
  logic        out_saturated;
  logic        out_last_feature;

  hand_landmark_feature_extractor uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_coord_x        (in_coord_x),
    .in_coord_y        (in_coord_y),
    .in_coord_z        (in_coord_z),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_feature_index (out_feature_index),
    .out_feature_value (out_feature_value),
    .out_saturated     (out_saturated),
    .out_last_feature  (out_last_feature)
  );

  // joint triplets (outer, joint, inner) and distance pairs
  localparam int JOINT_P [15] = '{0, 1, 2, 0, 5, 6, 0, 9, 10, 0, 13, 14, 0, 17, 18};
  localparam int JOINT_J [15] = '{1, 2, 3, 5, 6, 7, 9, 10, 11, 13, 14, 15, 17, 18, 19};
  localparam int JOINT_C [15] = '{2, 3, 4, 6, 7, 8, 10, 11, 12, 14, 15, 16, 18, 19, 20};
  localparam int PAIR_A [15] = '{4, 4, 4, 4, 8, 8, 8, 12, 12, 16, 0, 0, 0, 0, 0};
  localparam int PAIR_B [15] = '{8, 12, 16, 20, 12, 16, 20, 16, 20, 20, 4, 8, 12, 16, 20};

  // predictor state: landmarks of the hand being loaded
  longint   hand_x [21];
  longint   hand_y [21];
  longint   hand_z [21];
  int       landmarks_held;
  feature_t expected_features [$];

  int  error_count;
  int  words_sent;
  int  hands_sent;
  int  features_checked;
  int  saturated_seen;
  bit  send_gaps;
  bit  recv_stalls;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // angle at joint j between the outer and inner landmark, Q2.14 radians
  function automatic logic [15:0] joint_angle(int p, int j, int c);
    longint ax, ay, az, bx, by, bz;
    longint dot, c0, c1, c2, x, y, z, t, nx, ny;
    longint unsigned cross_sq;
    ax = hand_x[p] - hand_x[j];
    ay = hand_y[p] - hand_y[j];
    az = hand_z[p] - hand_z[j];
    bx = hand_x[c] - hand_x[j];
    by = hand_y[c] - hand_y[j];
    bz = hand_z[c] - hand_z[j];
    if ((ax == 0 && ay == 0 && az == 0) || (bx == 0 && by == 0 && bz == 0))
      return 16'd0;
    // halve toward zero until every component fits 15 bits
    while (ax >= 32768 || ax <= -32768 || ay >= 32768 || ay <= -32768 ||
           az >= 32768 || az <= -32768) begin
      ax = ax / 2; ay = ay / 2; az = az / 2;
    end
    while (bx >= 32768 || bx <= -32768 || by >= 32768 || by <= -32768 ||
           bz >= 32768 || bz <= -32768) begin
      bx = bx / 2; by = by / 2; bz = bz / 2;
    end
    dot = ax * bx + ay * by + az * bz;
    c0 = ay * bz - az * by;
    c1 = az * bx - ax * bz;
    c2 = ax * by - ay * bx;
    cross_sq = longint'(c0 * c0) + longint'(c1 * c1) + longint'(c2 * c2);
    y = longint'(sqrt_floor(cross_sq));
    x = dot;
    z = 0;
    // obtuse: pre-rotate by -pi/2 so CORDIC starts in the right half plane
    if (x < 0) begin
      t = x; x = y; y = -t; z = HALF_PI_Q16;
    end
    for (int i = 0; i < CORDIC_STEPS && y != 0; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z = z + longint'(ATAN_Q16[i]);
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z = z - longint'(ATAN_Q16[i]);
      end
      x = nx; y = ny;
    end
    if (z < 0) z = 0;
    if (z > PI_Q16) z = PI_Q16;
    z = (z + 2) >>> 2;
    if (z > PI_Q14) z = PI_Q14;
    return z[15:0];
  endfunction

  function automatic longint unsigned span_sq(int a, int b);
    longint dx, dy, dz;
    dx = hand_x[a] - hand_x[b];
    dy = hand_y[a] - hand_y[b];
    dz = hand_z[a] - hand_z[b];
    return longint'(dx * dx + dy * dy + dz * dz);
  endfunction

  // landmark taken by the block: store it, and on the last one queue the features
  task automatic take_landmark(coord_t x, coord_t y, coord_t z);
    longint unsigned hand_sq, d2, v;
    feature_t f;
    hand_x[landmarks_held] = x;
    hand_y[landmarks_held] = y;
    hand_z[landmarks_held] = z;
    words_sent++;
    if (landmarks_held < LANDMARK_COUNT - 1) begin
      landmarks_held++;
      return;
    end
    landmarks_held = 0;
    hands_sent++;
    for (int i = 0; i < NUM_ANGLES; i++) begin
      f.idx   = 5'(i);
      f.value = joint_angle(JOINT_P[i], JOINT_J[i], JOINT_C[i]);
      f.sat   = 1'b0;
      f.last  = 1'b0;
      expected_features.push_back(f);
    end
    hand_sq = span_sq(MID_KNUCKLE, WRIST);
    for (int i = 0; i < 15; i++) begin
      d2 = span_sq(PAIR_A[i], PAIR_B[i]);
      // zero hand length: scale is 1.0
      if (hand_sq == 0) v = sqrt_floor(d2);
      else v = sqrt_floor((d2 << 24) / hand_sq);
      f.idx   = 5'(NUM_ANGLES + i);
      f.sat   = (v > FEAT_MAX);
      f.value = f.sat ? 16'hFFFF : v[15:0];
      f.last  = (i == 14);
      expected_features.push_back(f);
    end
  endtask

  // one landmark word; valid stays up across back-to-back words
  task automatic send_landmark(coord_t x, coord_t y, coord_t z);
    int gap;
    in_valid   <= 1'b1;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    take_landmark(x, y, z);
    gap = send_gaps ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_hand(coord_t hx [21], coord_t hy [21], coord_t hz [21]);
    for (int i = 0; i < LANDMARK_COUNT; i++) send_landmark(hx[i], hy[i], hz[i]);
  endtask

  function automatic coord_t near(coord_t base, int spread);
    int v;
    v = int'(base) + $urandom_range(0, 2 * spread) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return coord_t'(v);
  endfunction

  task automatic send_random_hand(hand_kind_t kind);
    coord_t hx [21], hy [21], hz [21];
    coord_t px [3], py [3], pz [3];
    int spread;
    spread = $urandom_range(1, 3) == 1 ? 12000 : $urandom_range(50, 4000);
    for (int k = 0; k < 3; k++) begin
      px[k] = coord_t'($urandom_range(0, 8)) * 16'sd100;
      py[k] = coord_t'($urandom_range(0, 2)) * 16'sd100;
      pz[k] = coord_t'($urandom_range(0, 1)) * 16'sd100;
    end
    hx[0] = coord_t'($urandom);
    hy[0] = coord_t'($urandom);
    hz[0] = coord_t'($urandom);
    for (int i = 0; i < LANDMARK_COUNT; i++) begin
      case (kind)
        HAND_SCATTER: begin
          hx[i] = coord_t'($urandom); hy[i] = coord_t'($urandom); hz[i] = coord_t'($urandom);
        end
        HAND_DEGEN: begin
          int k;
          k = $urandom_range(0, 2);
          hx[i] = px[k]; hy[i] = py[k]; hz[i] = pz[k];
        end
        default: begin
          if (i > 0) begin
            hx[i] = near(hx[0], spread);
            hy[i] = near(hy[0], spread);
            hz[i] = near(hz[0], spread);
          end
        end
      endcase
    end
    if (kind == HAND_FLAT) begin
      hx[MID_KNUCKLE] = hx[WRIST]; hy[MID_KNUCKLE] = hy[WRIST]; hz[MID_KNUCKLE] = hz[WRIST];
    end
    send_hand(hx, hy, hz);
  endtask

  // hand built by hand: full-scale coordinates, zero vectors, straight and
  // right-angle joints, zero hand length with clipped distances
  task automatic test_extreme_hand();
    coord_t hx [21], hy [21], hz [21];
    for (int i = 0; i < LANDMARK_COUNT; i++) begin
      hx[i] = coord_t'(i * 1500 - 15000);
      hy[i] = coord_t'((i % 5) * 3000);
      hz[i] = coord_t'(-(i % 3) * 7000);
    end
    hx[0] = -16'sd32768; hy[0] = -16'sd32768; hz[0] = -16'sd32768;
    hx[1] = hx[0]; hy[1] = hy[0]; hz[1] = hz[0];        // zero vector at joint 1
    hx[4] = 16'sd32767; hy[4] = 16'sd32767; hz[4] = 16'sd32767;
    hx[5] = 16'sd0; hy[5] = 16'sd0; hz[5] = 16'sd0;
    hx[6] = 16'sd1000; hy[6] = 16'sd0; hz[6] = 16'sd0;
    hx[7] = 16'sd2000; hy[7] = 16'sd0; hz[7] = 16'sd0;  // straight joint: pi
    hx[8] = 16'sd1000; hy[8] = 16'sd0; hz[8] = 16'sd0;  // folded back: 0
    hx[9] = hx[0]; hy[9] = hy[0]; hz[9] = hz[0];        // zero hand length
    hx[10] = 16'sd0; hy[10] = 16'sd0; hz[10] = 16'sd0;
    hx[11] = 16'sd0; hy[11] = 16'sd1000; hz[11] = 16'sd0;
    hx[12] = 16'sd1000; hy[12] = 16'sd1000; hz[12] = 16'sd0;  // right angle
    hx[16] = 16'sd32767; hy[16] = -16'sd32768; hz[16] = 16'sd32767;
    hx[20] = -16'sd32768; hy[20] = 16'sd32767; hz[20] = -16'sd1;
    send_hand(hx, hy, hz);
  endtask

  task automatic test_random_hands(int count);
    for (int h = 0; h < count; h++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_random_hand(HAND_NATURAL);
        5, 6:          send_random_hand(HAND_SCATTER);
        7, 8:          send_random_hand(HAND_DEGEN);
        default:       send_random_hand(HAND_FLAT);
      endcase
    end
  endtask

  // sender holds off until the block has drained, then a hand at full rate
  task automatic test_drain_then_burst();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_features.size() != 0) @(posedge clk);
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    send_random_hand(HAND_NATURAL);
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
  endtask

  // receiver: random stalls of random length, or always ready
  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (!recv_stalls || out_ready == 1'b0) begin
        out_ready <= 1'b1;
        hold = $urandom_range(0, 20);
      end else begin
        hold = idle_len();
        if (hold > 0) out_ready <= 1'b0;
      end
    end
  end

  // compare every accepted feature word with the oldest prediction
  always @(posedge clk) begin
    feature_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_features.size() == 0) begin
        $display("%0t: unexpected feature word idx=%0d value=%0d", $realtime,
                 out_feature_index, out_feature_value);
        error_count++;
      end else begin
        want = expected_features.pop_front();
        features_checked++;
        if (out_saturated) saturated_seen++;
        if (out_feature_index !== want.idx) begin
          $display("%0t: feature_index expected %0d actual %0d", $realtime,
                   want.idx, out_feature_index);
          error_count++;
        end
        if (out_feature_value !== want.value) begin
          $display("%0t: feature %0d value expected %0d actual %0d", $realtime,
                   want.idx, want.value, out_feature_value);
          error_count++;
        end
        if (out_saturated !== want.sat) begin
          $display("%0t: feature %0d saturated expected %0b actual %0b", $realtime,
                   want.idx, want.sat, out_saturated);
          error_count++;
        end
        if (out_last_feature !== want.last) begin
          $display("%0t: feature %0d last expected %0b actual %0b", $realtime,
                   want.idx, want.last, out_last_feature);
          error_count++;
        end
      end
    end
  end

  initial begin
    error_count      = 0;
    words_sent       = 0;
    hands_sent       = 0;
    features_checked = 0;
    saturated_seen   = 0;
    landmarks_held   = 0;
    send_gaps        = 1'b1;
    recv_stalls      = 1'b1;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_coord_x = '0;
    in_coord_y = '0;
    in_coord_z = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extreme_hand();
    test_random_hands(3);
    test_drain_then_burst();
    test_random_hands(2);

    in_valid <= 1'b0;
    while (expected_features.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d landmark words in %0d hands; checked %0d feature words",
             words_sent, hands_sent, features_checked);
    $display("(%0d clipped distances), with random gaps and output stalls",
             saturated_seen);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
